// ===== design/dbas_pkg.sv =====
// ----------------------------------------------------------------------------
// dbas_pkg
// Shared widths and hash constants for the bitmap duplicate filter with
// adaptive sampling.
// ----------------------------------------------------------------------------
`default_nettype none

package dbas_pkg;

    // Fixed field widths.
    localparam int ID_W         = 32;
    localparam int RATE_W       = 17;
    localparam int ONES_FIELD_W = 17;
    localparam int COUNT_W      = 32;

    // Rate is Q1.16, so the sampling test scales the left-hand side by 2^16.
    localparam int RATE_FRAC_W  = 16;

    // Bitmap rows: 32 bits per memory word.
    localparam int ROW_W        = 32;
    localparam int ROW_SEL_W    = 5;

    // Hash: one 32-bit block, fixed seed.
    localparam logic [31:0] HASH_SEED = 32'd12412;
    localparam logic [31:0] HASH_C1   = 32'hcc9e2d51;
    localparam logic [31:0] HASH_C2   = 32'h1b873593;
    localparam logic [31:0] HASH_ADD  = 32'he6546b64;
    localparam logic [31:0] HASH_LEN  = 32'd4;
    localparam logic [31:0] HASH_F1   = 32'h85ebca6b;
    localparam logic [31:0] HASH_F2   = 32'hc2b2ae35;

endpackage

`default_nettype wire

// ===== design/dbas_hash_index.sv =====
// ----------------------------------------------------------------------------
// dbas_hash_index
// Iterative 32-bit word hash with one shared multiplier, followed by the
// reduction of the hash to a bitmap index.
// ----------------------------------------------------------------------------
`default_nettype none

module dbas_hash_index
    import dbas_pkg::*;
#(
    parameter int BITMAP_BITS = 65536
)
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    input  wire logic [ID_W-1:0]                    word,
    output logic                                    done,
    output logic [$clog2(BITMAP_BITS)-1:0]          index
);

    localparam int IDX_W = $clog2(BITMAP_BITS);
    localparam bit IS_POW2 = ((BITMAP_BITS & (BITMAP_BITS - 1)) == 0);
    // floor(2^32 / BITMAP_BITS); the quotient it gives is short by at most one.
    localparam logic [ID_W-1:0] RECIP = ID_W'(64'h1_0000_0000 / 64'(BITMAP_BITS));
    localparam logic [IDX_W:0]  MOD_N = (IDX_W + 1)'(BITMAP_BITS);

    typedef enum logic [3:0] {
        H_IDLE,
        H_K2,
        H_MIX,
        H_F1,
        H_F2,
        H_F3,
        H_QUO,
        H_REM,
        H_FIX,
        H_DONE
    } hash_state_t;

    hash_state_t        state_reg;
    logic [ID_W-1:0]    acc_reg;
    logic [ID_W-1:0]    quo_reg;
    logic [IDX_W:0]     rem_reg;
    logic [IDX_W-1:0]   idx_reg;

    logic [ID_W-1:0]    mul_a;
    logic [ID_W-1:0]    mul_b;
    logic [ID_W-1:0]    mul_p;
    logic [ID_W-1:0]    mix_h;
    logic [ID_W-1:0]    fin_h;
    logic [2*ID_W-1:0]  quo_full;
    logic [ID_W-1:0]    rem_diff;
    logic [IDX_W:0]     rem_fix;

    // One multiplier serves all four constant multiplications in turn.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            H_IDLE:
            begin
                mul_a = word;
                mul_b = HASH_C1;
            end
            H_K2:
            begin
                mul_a = {acc_reg[16:0], acc_reg[31:17]};
                mul_b = HASH_C2;
            end
            H_F1:
            begin
                mul_a = acc_reg;
                mul_b = HASH_F1;
            end
            H_F2:
            begin
                mul_a = acc_reg ^ (acc_reg >> 13);
                mul_b = HASH_F2;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // Mixing into the seed, the length term and the first finalising shift.
    always_comb
    begin
        mix_h = HASH_SEED ^ acc_reg;
        mix_h = {mix_h[18:0], mix_h[31:19]};
        mix_h = (mix_h << 2) + mix_h + HASH_ADD;
        mix_h = mix_h ^ HASH_LEN;
        mix_h = mix_h ^ (mix_h >> 16);
        fin_h = acc_reg ^ (acc_reg >> 16);
    end

    // Reduction by a size that is not a power of two: the reciprocal gives a
    // quotient at most one short, so the remainder it leaves is below twice
    // the size and a single conditional subtraction completes it.
    always_comb
    begin
        quo_full = (2 * ID_W)'(acc_reg) * (2 * ID_W)'(RECIP);
        rem_diff = acc_reg - quo_reg * ID_W'(BITMAP_BITS);
        if (rem_reg >= MOD_N)
        begin
            rem_fix = rem_reg - MOD_N;
        end
        else
        begin
            rem_fix = rem_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= H_IDLE;
            acc_reg   <= '0;
            quo_reg   <= '0;
            rem_reg   <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                H_IDLE:
                begin
                    if (start)
                    begin
                        acc_reg   <= mul_p;
                        state_reg <= H_K2;
                    end
                end
                H_K2:
                begin
                    acc_reg   <= mul_p;
                    state_reg <= H_MIX;
                end
                H_MIX:
                begin
                    acc_reg   <= mix_h;
                    state_reg <= H_F1;
                end
                H_F1:
                begin
                    acc_reg   <= mul_p;
                    state_reg <= H_F2;
                end
                H_F2:
                begin
                    acc_reg   <= mul_p;
                    state_reg <= H_F3;
                end
                H_F3:
                begin
                    if (IS_POW2)
                    begin
                        idx_reg   <= fin_h[IDX_W-1:0];
                        state_reg <= H_DONE;
                    end
                    else
                    begin
                        acc_reg   <= fin_h;
                        state_reg <= H_QUO;
                    end
                end
                H_QUO:
                begin
                    quo_reg   <= quo_full[2*ID_W-1:ID_W];
                    state_reg <= H_REM;
                end
                H_REM:
                begin
                    rem_reg   <= rem_diff[IDX_W:0];
                    state_reg <= H_FIX;
                end
                H_FIX:
                begin
                    idx_reg   <= rem_fix[IDX_W-1:0];
                    state_reg <= H_DONE;
                end
                H_DONE:
                begin
                    state_reg <= H_IDLE;
                end
                default:
                begin
                    state_reg <= H_IDLE;
                end
            endcase
        end
    end

    assign done  = (state_reg == H_DONE);
    assign index = idx_reg;

endmodule

`default_nettype wire

// ===== design/dedup_bitmap_adaptive_sampler.sv =====
// ----------------------------------------------------------------------------
// dedup_bitmap_adaptive_sampler
// Duplicate filter over a hashed bitmap with fill-adaptive sampling of new
// items.
// ----------------------------------------------------------------------------
// Usage
// The input channel (in_valid / in_stall) carries flow_id, element_id and
// port_id. Each input transaction yields exactly one output transaction
// (out_valid / out_stall) that echoes the three ids and reports whether the
// hashed bitmap bit was new, whether the item was sampled, the bitmap fill
// and the saturating sample count.
// The sampling rate is written through cfg_wr_en / cfg_wr_data; the user
// must write it only while the block is idle, which the block does not
// enforce. It resets to 6554 (about 0.1 in Q1.16).
// When BITMAP_BITS is not a power of two, the hash index is further reduced
// by a reciprocal multiplication, a remainder step and a conditional
// correction. One item is in flight at a time: the next item is accepted
// once the result of the last one has entered the output register.
// Reset: the bitmap memory, ceil(BITMAP_BITS / 32) rows (2048 at the default
// size), is cleared one 32-bit row per cycle; in_stall is high during the
// pass. Counters reset to zero.
// A stalled result waits in the output register; the next item is already
// accepted and processed, and it waits at its last step until the output
// register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module dedup_bitmap_adaptive_sampler
    import dbas_pkg::*;
#(
    parameter int BITMAP_BITS = 65536
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,

    input  wire logic                    cfg_wr_en,
    input  wire logic [RATE_W-1:0]       cfg_wr_data,

    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic [ID_W-1:0]         flow_id,
    input  wire logic [ID_W-1:0]         element_id,
    input  wire logic [ID_W-1:0]         port_id,

    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic [ID_W-1:0]              out_flow,
    output logic [ID_W-1:0]              out_element,
    output logic [ID_W-1:0]              out_port,
    output logic                         is_new,
    output logic                         is_sampled,
    output logic [ONES_FIELD_W-1:0]      ones_total,
    output logic [COUNT_W-1:0]           samples_total
);

    // Index and row geometry.
    localparam int IDX_W  = $clog2(BITMAP_BITS);
    localparam int ROWS   = (BITMAP_BITS + ROW_W - 1) / ROW_W;
    localparam int ROW_AW = IDX_W - ROW_SEL_W;
    localparam int ONES_W = $clog2(BITMAP_BITS + 1);

    // Sampling test: idx * free * 2^16 < rate * BITMAP_BITS^2.
    // The square is split in two halves so that each product stays narrow.
    localparam int SQ_W   = 2 * IDX_W + 1;
    localparam int HALF_W = (SQ_W + 1) / 2;
    localparam int PP_W   = RATE_W + HALF_W;
    localparam int RHS_W  = RATE_W + SQ_W + 1;
    localparam int PROD_W = IDX_W + ONES_W;
    localparam logic [SQ_W-1:0] BITMAP_SQ =
        SQ_W'(64'(BITMAP_BITS) * 64'(BITMAP_BITS));
    localparam logic [HALF_W-1:0] SQ_LO = BITMAP_SQ[HALF_W-1:0];
    localparam logic [HALF_W-1:0] SQ_HI = HALF_W'(BITMAP_SQ >> HALF_W);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_READ,
        S_CMP
    } core_state_t;

    core_state_t            state_reg;
    logic [ROW_AW-1:0]      clr_row_reg;
    logic [IDX_W-1:0]       idx_reg;
    logic                   new_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic [ONES_W-1:0]      ones_reg;
    logic [COUNT_W-1:0]     samples_reg;
    logic [ID_W-1:0]        flow_reg;
    logic [ID_W-1:0]        element_reg;
    logic [ID_W-1:0]        port_reg;

    logic [RATE_W-1:0]      rate_reg;
    logic [PP_W-1:0]        pp_lo_reg;
    logic [PP_W-1:0]        pp_hi_reg;
    logic [RHS_W-1:0]       rhs_reg;

    logic                   out_valid_reg;
    logic [ID_W-1:0]        out_flow_reg;
    logic [ID_W-1:0]        out_element_reg;
    logic [ID_W-1:0]        out_port_reg;
    logic                   out_new_reg;
    logic                   out_sampled_reg;
    logic [ONES_FIELD_W-1:0] out_ones_reg;

    // Bitmap memory, one read and one write port, registered read data.
    logic [ROW_W-1:0]       bitmap_mem [ROWS];
    logic [ROW_W-1:0]       rd_data_reg;
    logic                   rd_en;
    logic [ROW_AW-1:0]      rd_addr;
    logic                   wr_en;
    logic [ROW_AW-1:0]      wr_addr;
    logic [ROW_W-1:0]       wr_data;

    logic                   hash_done;
    logic [IDX_W-1:0]       hash_idx;

    logic                   in_accept;
    logic                   out_take;
    logic                   out_free;
    logic                   bit_seen;
    logic [ROW_W-1:0]       bit_mask;
    logic [ONES_W-1:0]      free_bits;
    logic                   pass_test;
    logic                   sample_now;

    dbas_hash_index #(
        .BITMAP_BITS (BITMAP_BITS)
    ) u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (in_accept),
        .word  (flow_id ^ element_id ^ port_id),
        .done  (hash_done),
        .index (hash_idx)
    );

    // Only one item is in flight, so a bitmap row is never read while an
    // earlier write to it is still pending.
    always_comb
    begin
        in_stall  = (state_reg != S_IDLE);
        in_accept = in_valid && !in_stall;
        out_take  = out_valid_reg && !out_stall;
        out_free  = !out_valid_reg || !out_stall;

        bit_mask  = ROW_W'(1) << idx_reg[ROW_SEL_W-1:0];
        bit_seen  = rd_data_reg[idx_reg[ROW_SEL_W-1:0]];
        free_bits = ONES_W'(BITMAP_BITS) - ones_reg;

        rd_en   = (state_reg == S_HASH) && hash_done;
        rd_addr = hash_idx[IDX_W-1:ROW_SEL_W];

        if (state_reg == S_CLEAR)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_row_reg;
            wr_data = '0;
        end
        else
        begin
            wr_en   = (state_reg == S_READ) && !bit_seen;
            wr_addr = idx_reg[IDX_W-1:ROW_SEL_W];
            wr_data = rd_data_reg | bit_mask;
        end

        pass_test  = RHS_W'({prod_reg, {RATE_FRAC_W{1'b0}}}) < rhs_reg;
        sample_now = new_reg && pass_test;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            bitmap_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= bitmap_mem[rd_addr];
        end
    end

    // Right-hand side of the sampling test follows the rate register through
    // the partial-product registers and rhs_reg; an item needs far longer to reach the comparison.
    always_ff @(posedge clk)
    begin
        pp_lo_reg <= PP_W'(rate_reg) * PP_W'(SQ_LO);
        pp_hi_reg <= PP_W'(rate_reg) * PP_W'(SQ_HI);
        rhs_reg   <= (RHS_W'(pp_hi_reg) << HALF_W) + RHS_W'(pp_lo_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg <= RATE_W'(6554);
        end
        else if (cfg_wr_en)
        begin
            rate_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_row_reg     <= '0;
            idx_reg         <= '0;
            new_reg         <= 1'b0;
            prod_reg        <= '0;
            ones_reg        <= '0;
            samples_reg     <= '0;
            flow_reg        <= '0;
            element_reg     <= '0;
            port_reg        <= '0;
            out_valid_reg   <= 1'b0;
            out_flow_reg    <= '0;
            out_element_reg <= '0;
            out_port_reg    <= '0;
            out_new_reg     <= 1'b0;
            out_sampled_reg <= 1'b0;
            out_ones_reg    <= '0;
        end
        else
        begin
            if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_CLEAR:
                begin
                    clr_row_reg <= clr_row_reg + 1'b1;
                    if (clr_row_reg == ROW_AW'(ROWS - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        flow_reg    <= flow_id;
                        element_reg <= element_id;
                        port_reg    <= port_id;
                        state_reg   <= S_HASH;
                    end
                end
                S_HASH:
                begin
                    if (hash_done)
                    begin
                        idx_reg   <= hash_idx;
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    // The free count uses the fill before this item.
                    new_reg  <= !bit_seen;
                    prod_reg <= PROD_W'(idx_reg) * PROD_W'(free_bits);
                    if (!bit_seen)
                    begin
                        ones_reg <= ones_reg + 1'b1;
                    end
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    if (out_free)
                    begin
                        if (sample_now && (samples_reg != '1))
                        begin
                            samples_reg <= samples_reg + 1'b1;
                        end
                        out_valid_reg   <= 1'b1;
                        out_flow_reg    <= flow_reg;
                        out_element_reg <= element_reg;
                        out_port_reg    <= port_reg;
                        out_new_reg     <= new_reg;
                        out_sampled_reg <= sample_now;
                        out_ones_reg    <= ONES_FIELD_W'(ones_reg);
                        state_reg       <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_flow      = out_flow_reg;
    assign out_element   = out_element_reg;
    assign out_port      = out_port_reg;
    assign is_new        = out_new_reg;
    assign is_sampled    = out_sampled_reg;
    assign ones_total    = out_ones_reg;
    // The sample count register already includes this item when it is shown.
    assign samples_total = samples_reg;

endmodule

`default_nettype wire
